/* hw/rtl/stsc_pkg.sv */
// Shared types, constants and character helper functions for the source token scanner.
`default_nettype none

package stsc_pkg;

    localparam int MAX_TOKEN_LEN_DEF = 255;
    localparam int POSITION_BITS_DEF = 32;
    localparam int MAX_RESULTS       = 3;
    localparam int OUTQ_DEPTH        = 5;
    localparam int OUTQ_CNT_W        = $clog2(OUTQ_DEPTH + 1);
    localparam int NUM_KEYWORDS      = 6;

    localparam logic [62:0] LIT_MAX = {63{1'b1}};

    typedef enum logic [4:0] {
        KIND_IDENT    = 5'd0,
        KIND_INT      = 5'd1,
        KIND_FLOAT    = 5'd2,
        KIND_FN       = 5'd3,
        KIND_INT32    = 5'd4,
        KIND_RETURN   = 5'd5,
        KIND_NIL      = 5'd6,
        KIND_LPAREN   = 5'd7,
        KIND_RPAREN   = 5'd8,
        KIND_LBRACE   = 5'd9,
        KIND_RBRACE   = 5'd10,
        KIND_LBRACKET = 5'd11,
        KIND_RBRACKET = 5'd12,
        KIND_SEMI     = 5'd13,
        KIND_ARROW    = 5'd14,
        KIND_ERROR    = 5'd15,
        KIND_END      = 5'd16
    } kind_t;

    typedef enum logic [2:0] {
        CAUSE_NONE    = 3'd0,
        CAUSE_UNKNOWN = 3'd1,
        CAUSE_DOT     = 3'd2,
        CAUSE_EXP     = 3'd3,
        CAUSE_LETTER  = 3'd4,
        CAUSE_LONG    = 3'd5
    } cause_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_IDENT  = 3'd1,
        MODE_NUM    = 3'd2,
        MODE_NUMBAD = 3'd3,
        MODE_DOT    = 3'd4,
        MODE_OP     = 3'd5,
        MODE_OVER   = 3'd6
    } mode_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] off;
        logic [31:0] line;
        logic [31:0] col;
        logic [7:0]  len;
        logic [62:0] value;
        cause_t      cause;
        logic        seen;
        logic        last;
    } rec_t;

    typedef struct packed {
        logic   dot;
        logic   exp;
        cause_t cause;
    } numf_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_e(input logic [7:0] c);
        return c == "e" || c == "E";
    endfunction

    function automatic logic [3:0] kw_len(input logic [2:0] k);
        logic [3:0] r;
        case (k)
            3'd0: r = 4'd2;
            3'd1: r = 4'd3;
            3'd2: r = 4'd5;
            3'd3: r = 4'd3;
            3'd4: r = 4'd6;
            3'd5: r = 4'd3;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic kind_t kw_kind(input logic [2:0] k);
        kind_t r;
        case (k)
            3'd0: r = KIND_FN;
            3'd1: r = KIND_INT32;
            3'd2: r = KIND_INT32;
            3'd3: r = KIND_INT32;
            3'd4: r = KIND_RETURN;
            3'd5: r = KIND_NIL;
            default: r = KIND_IDENT;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_byte(input logic [2:0] k, input logic [2:0] i);
        logic [47:0] s;
        case (k)
            3'd0: s = {"\0\0\0\0", "nf"};
            3'd1: s = {"\0\0\0", "23i"};
            3'd2: s = {"\0", "23tni"};
            3'd3: s = {"\0\0\0", "tni"};
            3'd4: s = "nruter";
            3'd5: s = {"\0\0\0", "lin"};
            default: s = '0;
        endcase
        return (i < 3'd6) ? s[i*8 +: 8] : 8'd0;
    endfunction

    function automatic logic op_pair(input logic [7:0] f, input logic [7:0] s);
        logic r;
        case (f)
            "+": r = (s == "+") || (s == "=");
            "-": r = (s == "-") || (s == "=") || (s == ">");
            "*": r = (s == "=");
            "/": r = (s == "/") || (s == "*") || (s == "=");
            "%": r = (s == "=");
            "=": r = (s == "=");
            "|": r = (s == "|");
            "&": r = (s == "&");
            "^": r = (s == "^");
            "<": r = (s == "<") || (s == "=");
            "!": r = (s == "!") || (s == "=");
            ">": r = (s == ">") || (s == "=");
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] cnt_up(input logic [7:0] c);
        return (c != 8'hFF) ? c + 8'd1 : c;
    endfunction

    function automatic logic [5:0] kw_update(input logic [5:0] cand, input logic [7:0] idx,
                                             input logic [7:0] c);
        logic [5:0] r;
        r = cand;
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            if (idx >= {4'd0, kw_len(3'(k))} || kw_byte(3'(k), idx[2:0]) != c) begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [62:0] acc_update(input logic [62:0] acc, input logic [7:0] c);
        logic [66:0] wide;
        logic [62:0] r;
        wide = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {59'd0, c - 8'd48};
        r = acc;
        if (is_digit(c)) begin
            r = (wide > {4'd0, LIT_MAX}) ? LIT_MAX : wide[62:0];
        end
        return r;
    endfunction

    function automatic numf_t numf_update(input numf_t f, input logic [7:0] c);
        numf_t r;
        r = f;
        if (c == ".") begin
            if (r.dot) begin
                if (r.cause == CAUSE_NONE) r.cause = CAUSE_DOT;
            end else begin
                r.dot = 1'b1;
            end
        end
        if (is_e(c)) begin
            if (r.exp) begin
                if (r.cause == CAUSE_NONE) r.cause = CAUSE_EXP;
            end else begin
                r.exp = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic logic num_err(input numf_t f, input logic [7:0] c);
        return (c == "." && f.dot) || (is_e(c) && f.exp);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/source_token_scanner_top.sv */
// Source token scanner: one source byte per beat in, one token record per beat out.
// Records for a byte are built combinationally and registered in the result queue.
// Throughput: one byte per cycle while at most two records wait in the result queue;
// the input side stalls in every cycle that begins with three or more records queued.
// Reset: aresetn is synchronous and active low; it empties the queue and restores
// the scanner to its start state at offset 0, line 1, column 1.
`default_nettype none

module source_token_scanner_top import stsc_pkg::*; #(
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,  // in_byte
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [167:0]      m_tdata,  // start_offset, line_number, column_number,
                                        // token_length, literal_value, zero pad
    output logic [8:0]        m_tuser,  // token_kind, error_cause, error_seen
    output logic              m_tlast
);

    rec_t       recs [MAX_RESULTS];
    logic [1:0] rec_count;
    logic       fire;
    rec_t       head;

    assign fire = s_tvalid && s_tready;

    stsc_scan #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .POSITION_BITS (POSITION_BITS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .recs      (recs),
        .rec_count (rec_count)
    );

    stsc_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (fire),
        .push_count (rec_count),
        .push_recs  (recs),
        .room       (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_rec    (head)
    );

    assign m_tdata = {1'b0, head.value, head.len, head.col, head.line, head.off};
    assign m_tuser = {head.seen, head.cause, head.kind};
    assign m_tlast = head.last;

endmodule

`default_nettype wire

/* hw/rtl/stsc_scan.sv */
// Scanner state registers and the per-byte record generation logic.
`default_nettype none

module stsc_scan import stsc_pkg::*; #(
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       fire,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output rec_t            recs [MAX_RESULTS],
    output logic [1:0]      rec_count
);

    localparam int POS_W = (POSITION_BITS > 32) ? 32 : POSITION_BITS;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);
    localparam logic [7:0] MAX_LEN = 8'(MAX_TOKEN_LEN);

    mode_t            mode_reg, mode_next;
    logic [7:0]       pend_reg, pend_next;
    logic [POS_W-1:0] toff_reg, toff_next, tline_reg, tline_next, tcol_reg, tcol_next;
    logic [7:0]       cnt_reg, cnt_next;
    logic [5:0]       cand_reg, cand_next;
    numf_t            numf_reg, numf_next;
    logic [62:0]      acc_reg, acc_next;
    logic [POS_W-1:0] coff_reg, coff_next, cline_reg, cline_next, ccol_reg, ccol_next;
    logic             err_reg, err_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            pend_reg  <= '0;
            toff_reg  <= '0;
            tline_reg <= POS_ONE;
            tcol_reg  <= POS_ONE;
            cnt_reg   <= '0;
            cand_reg  <= '1;
            numf_reg  <= '0;
            acc_reg   <= '0;
            coff_reg  <= '0;
            cline_reg <= POS_ONE;
            ccol_reg  <= POS_ONE;
            err_reg   <= 1'b0;
        end else if (fire) begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            toff_reg  <= toff_next;
            tline_reg <= tline_next;
            tcol_reg  <= tcol_next;
            cnt_reg   <= cnt_next;
            cand_reg  <= cand_next;
            numf_reg  <= numf_next;
            acc_reg   <= acc_next;
            coff_reg  <= coff_next;
            cline_reg <= cline_next;
            ccol_reg  <= ccol_next;
            err_reg   <= err_next;
        end
    end

    function automatic rec_t mk_rec(input kind_t kind, input logic [POS_W-1:0] off,
                                    input logic [POS_W-1:0] ln, input logic [POS_W-1:0] col,
                                    input logic [7:0] len, input logic [62:0] value,
                                    input cause_t cause, input logic seen, input logic last);
        rec_t r;
        r.kind  = kind;
        r.off   = 32'(off);
        r.line  = 32'(ln);
        r.col   = 32'(col);
        r.len   = len;
        r.value = value;
        r.cause = cause;
        r.seen  = seen;
        r.last  = last;
        return r;
    endfunction

    always_comb begin
        logic       fall;
        logic       alnum;
        logic       has_close;
        kind_t      ckind;
        logic [62:0] cval;
        cause_t     ccause;
        logic [1:0] n;
        rec_t       closed;

        mode_next  = mode_reg;
        pend_next  = pend_reg;
        toff_next  = toff_reg;
        tline_next = tline_reg;
        tcol_next  = tcol_reg;
        cnt_next   = cnt_reg;
        cand_next  = cand_reg;
        numf_next  = numf_reg;
        acc_next   = acc_reg;
        coff_next  = coff_reg;
        cline_next = cline_reg;
        ccol_next  = ccol_reg;
        err_next   = err_reg;
        n          = 2'd0;
        fall       = 1'b0;
        closed     = '0;
        ckind      = KIND_IDENT;
        cval       = '0;
        ccause     = CAUSE_NONE;
        has_close  = 1'b0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            recs[i] = '0;
        end
        alnum = is_alpha(in_byte) || is_digit(in_byte);

        case (mode_next)
            MODE_IDENT: begin
                if (alnum || in_byte == "_") begin
                    if (cnt_next >= MAX_LEN) begin
                        err_next = 1'b1;
                        recs[n] = mk_rec(KIND_ERROR, toff_next, tline_next, tcol_next,
                                         cnt_next, '0, CAUSE_LONG, 1'b1, 1'b0);
                        n = n + 2'd1;
                        mode_next = MODE_OVER;
                    end else begin
                        cand_next = kw_update(cand_next, cnt_next, in_byte);
                        cnt_next  = cnt_up(cnt_next);
                    end
                end else begin
                    has_close = 1'b1;
                    fall      = 1'b1;
                end
            end
            MODE_NUM: begin
                if (is_digit(in_byte) || in_byte == "." || is_e(in_byte)) begin
                    if (cnt_next >= MAX_LEN) begin
                        err_next = 1'b1;
                        recs[n] = mk_rec(KIND_ERROR, toff_next, tline_next, tcol_next,
                                         cnt_next, '0, CAUSE_LONG, 1'b1, 1'b0);
                        n = n + 2'd1;
                        mode_next = MODE_OVER;
                    end else begin
                        if (num_err(numf_next, in_byte)) err_next = 1'b1;
                        numf_next = numf_update(numf_next, in_byte);
                        acc_next  = acc_update(acc_next, in_byte);
                        cnt_next  = cnt_up(cnt_next);
                    end
                end else if (is_alpha(in_byte)) begin
                    mode_next = MODE_NUMBAD;
                    err_next  = 1'b1;
                    cnt_next  = cnt_up(cnt_next);
                end else begin
                    has_close = 1'b1;
                    fall      = 1'b1;
                end
            end
            MODE_NUMBAD: begin
                if (alnum) begin
                    cnt_next = cnt_up(cnt_next);
                end else begin
                    has_close = 1'b1;
                    fall      = 1'b1;
                end
            end
            MODE_DOT: begin
                mode_next = MODE_IDLE;
                if (is_digit(in_byte)) begin
                    mode_next = MODE_NUM;
                    numf_next = '{dot: 1'b1, exp: 1'b0, cause: CAUSE_NONE};
                    acc_next  = acc_update('0, in_byte);
                    cnt_next  = 8'd2;
                end else begin
                    fall = 1'b1;
                end
            end
            MODE_OP: begin
                mode_next = MODE_IDLE;
                if (op_pair(pend_next, in_byte)) begin
                    if (pend_next == "-" && in_byte == ">") begin
                        recs[n] = mk_rec(KIND_ARROW, toff_next, tline_next, tcol_next,
                                         8'd2, '0, CAUSE_NONE, err_next, 1'b0);
                        n = n + 2'd1;
                    end
                end else begin
                    fall = 1'b1;
                end
            end
            MODE_OVER: begin
                if (!(alnum || in_byte == "_" || in_byte == ".")) begin
                    mode_next = MODE_IDLE;
                    fall      = 1'b1;
                end
            end
            default: begin
                mode_next = MODE_IDLE;
                fall      = 1'b1;
            end
        endcase

        if (has_close) begin
            if (mode_next == MODE_IDENT) begin
                ckind = KIND_IDENT;
                for (int k = 0; k < NUM_KEYWORDS; k++) begin
                    if (cand_next[k] && cnt_next == {4'd0, kw_len(3'(k))}) begin
                        ckind = kw_kind(3'(k));
                    end
                end
            end else if (mode_next == MODE_NUM) begin
                if (numf_next.cause != CAUSE_NONE) begin
                    ckind  = KIND_ERROR;
                    ccause = numf_next.cause;
                end else if (numf_next.dot || numf_next.exp) begin
                    ckind = KIND_FLOAT;
                end else begin
                    ckind = KIND_INT;
                    cval  = acc_next;
                end
            end else begin
                err_next = 1'b1;
                ckind    = KIND_ERROR;
                ccause   = CAUSE_LETTER;
            end
            recs[n] = mk_rec(ckind, toff_next, tline_next, tcol_next, cnt_next, cval, ccause,
                             err_next, 1'b0);
            n = n + 2'd1;
            mode_next = MODE_IDLE;
        end

        if (fall) begin
            case (in_byte)
                " ", "\t", "\r", "\n", "@", ",", "#", ":", "\\", "\"", "'": begin
                end
                "(", ")", "{", "}", "[", "]", ";": begin
                    case (in_byte)
                        "(":     ckind = KIND_LPAREN;
                        ")":     ckind = KIND_RPAREN;
                        "{":     ckind = KIND_LBRACE;
                        "}":     ckind = KIND_RBRACE;
                        "[":     ckind = KIND_LBRACKET;
                        "]":     ckind = KIND_RBRACKET;
                        default: ckind = KIND_SEMI;
                    endcase
                    recs[n] = mk_rec(ckind, coff_reg, cline_reg, ccol_reg, 8'd1, '0,
                                     CAUSE_NONE, err_next, 1'b0);
                    n = n + 2'd1;
                end
                ".": begin
                    toff_next  = coff_reg;
                    tline_next = cline_reg;
                    tcol_next  = ccol_reg;
                    mode_next  = MODE_DOT;
                end
                "+", "-", "*", "/", "%", "=", "|", "&", "^", "<", "!", ">": begin
                    toff_next  = coff_reg;
                    tline_next = cline_reg;
                    tcol_next  = ccol_reg;
                    pend_next  = in_byte;
                    mode_next  = MODE_OP;
                end
                default: begin
                    if (is_alpha(in_byte) || in_byte == "_" || is_digit(in_byte)) begin
                        toff_next  = coff_reg;
                        tline_next = cline_reg;
                        tcol_next  = ccol_reg;
                        numf_next  = '0;
                        acc_next   = acc_update('0, in_byte);
                        cnt_next   = 8'd1;
                        if (is_digit(in_byte)) begin
                            mode_next = MODE_NUM;
                            cand_next = '1;
                        end else begin
                            mode_next = MODE_IDENT;
                            cand_next = kw_update('1, 8'd0, in_byte);
                        end
                    end else begin
                        err_next = 1'b1;
                        recs[n] = mk_rec(KIND_ERROR, coff_reg, cline_reg, ccol_reg, 8'd1,
                                         {55'd0, in_byte}, CAUSE_UNKNOWN, 1'b1, 1'b0);
                        n = n + 2'd1;
                    end
                end
            endcase
        end

        if (coff_reg != POS_MAX) coff_next = coff_reg + POS_ONE;
        if (in_byte == "\n") begin
            if (cline_reg != POS_MAX) cline_next = cline_reg + POS_ONE;
            ccol_next = POS_ONE;
        end else if (ccol_reg != POS_MAX) begin
            ccol_next = ccol_reg + POS_ONE;
        end

        if (in_last) begin
            if (mode_next == MODE_IDENT || mode_next == MODE_NUM
                    || mode_next == MODE_NUMBAD) begin
                ckind  = KIND_IDENT;
                cval   = '0;
                ccause = CAUSE_NONE;
                if (mode_next == MODE_IDENT) begin
                    for (int k = 0; k < NUM_KEYWORDS; k++) begin
                        if (cand_next[k] && cnt_next == {4'd0, kw_len(3'(k))}) begin
                            ckind = kw_kind(3'(k));
                        end
                    end
                end else if (mode_next == MODE_NUM) begin
                    if (numf_next.cause != CAUSE_NONE) begin
                        ckind  = KIND_ERROR;
                        ccause = numf_next.cause;
                    end else if (numf_next.dot || numf_next.exp) begin
                        ckind = KIND_FLOAT;
                    end else begin
                        ckind = KIND_INT;
                        cval  = acc_next;
                    end
                end else begin
                    err_next = 1'b1;
                    ckind    = KIND_ERROR;
                    ccause   = CAUSE_LETTER;
                end
                closed = mk_rec(ckind, toff_next, tline_next, tcol_next, cnt_next, cval,
                                ccause, err_next, 1'b0);
                recs[n] = closed;
                n = n + 2'd1;
            end
            recs[n] = mk_rec(KIND_END, coff_next, cline_next, ccol_next, 8'd0, '0,
                             CAUSE_NONE, err_next, 1'b1);
            n = n + 2'd1;
            mode_next  = MODE_IDLE;
            pend_next  = '0;
            toff_next  = '0;
            tline_next = POS_ONE;
            tcol_next  = POS_ONE;
            cnt_next   = '0;
            cand_next  = '1;
            numf_next  = '0;
            acc_next   = '0;
            coff_next  = '0;
            cline_next = POS_ONE;
            ccol_next  = POS_ONE;
            err_next   = 1'b0;
        end

        rec_count = n;
    end

endmodule

`default_nettype wire

/* hw/rtl/stsc_outq.sv */
// Result queue that takes up to three records per cycle and hands out one per beat.
`default_nettype none

module stsc_outq import stsc_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire logic [1:0] push_count,
    input  rec_t            push_recs [MAX_RESULTS],
    output logic            room,
    output logic            out_valid,
    input  wire logic       out_ready,
    output rec_t            out_rec
);

    rec_t                  q_reg [OUTQ_DEPTH];
    rec_t                  q_next [OUTQ_DEPTH];
    logic [OUTQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  pop;

    assign out_valid = (cnt_reg != '0);
    assign out_rec   = q_reg[0];
    assign pop       = out_valid && out_ready;
    assign room      = (cnt_reg <= OUTQ_CNT_W'(OUTQ_DEPTH - MAX_RESULTS));

    always_comb begin
        int j;
        int k;
        int pushed;
        pushed = push ? int'(push_count) : 0;
        for (int i = 0; i < OUTQ_DEPTH; i++) begin
            j = i + (pop ? 1 : 0);
            k = j - int'(cnt_reg);
            q_next[i] = q_reg[i];
            if (j < int'(cnt_reg)) begin
                q_next[i] = q_reg[3'(j)];
            end else if (k >= 0 && k < pushed) begin
                q_next[i] = push_recs[2'(k)];
            end
        end
        cnt_next = cnt_reg - OUTQ_CNT_W'(pop) + OUTQ_CNT_W'(pushed);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < OUTQ_DEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule

`default_nettype wire
